FILE: sv/pdb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pdb_pkg;

  // Distance conversion: d = floor(us * 272 / 1000) = floor(us * 34 / 125).
  localparam int ECHO_W    = 15;
  localparam int DIST_W    = 13;
  localparam int X_W       = 21;
  localparam int ECHO_MAX  = 19999;
  localparam int ECHO_MUL  = 34;
  localparam int ECHO_DIV  = 125;
  localparam int DIST_K    = 24;
  localparam int DIST_R    = (2 ** DIST_K) / ECHO_DIV;
  localparam int DIST_R_W  = 18;
  localparam int DIST_MAX  = 5439;

  localparam int IVL_W     = 10;
  localparam int IVL_RESET = 50;
  localparam int TIME_W    = 32;
  localparam int FREQ_W    = 11;
  localparam int PER_W     = 8;

  typedef struct packed {
    logic              reversing;
    logic [ECHO_W-1:0] echo_us;
  } pdb_in_t;

  typedef struct packed {
    logic              measured;
    logic              new_average;
    logic [DIST_W-1:0] average_q4;
    logic              sounding;
    logic [FREQ_W-1:0] tone_hz;
  } pdb_out_t;

  // Item after the first stage: echo range check and the reciprocal estimate.
  typedef struct packed {
    logic              reversing;
    logic              echo_ok;
    logic [X_W-1:0]    x;
    logic [DIST_W-1:0] q0;
  } pdb_conv_t;

  // Per-item flags and tick time handed down the pipeline.
  typedef struct packed {
    logic              reversing;
    logic              measured;
    logic              refreshed;
    logic [TIME_W-1:0] now;
  } pdb_tick_t;

  typedef struct packed {
    logic [FREQ_W-1:0] freq;
    logic [PER_W-1:0]  period;
  } pdb_band_t;

  function automatic pdb_band_t pick_band(input logic [DIST_W-1:0] avg);
    pdb_band_t b;
    if (avg <= DIST_W'(160)) begin
      b.freq = FREQ_W'(2000); b.period = PER_W'(30);
    end else if (avg <= DIST_W'(320)) begin
      b.freq = FREQ_W'(1500); b.period = PER_W'(50);
    end else if (avg <= DIST_W'(640)) begin
      b.freq = FREQ_W'(1000); b.period = PER_W'(100);
    end else if (avg <= DIST_W'(1120)) begin
      b.freq = FREQ_W'(700);  b.period = PER_W'(200);
    end else if (avg <= DIST_W'(1600)) begin
      b.freq = FREQ_W'(400);  b.period = PER_W'(250);
    end else begin
      b.freq = '0;            b.period = '0;
    end
    return b;
  endfunction

endpackage

`default_nettype wire

FILE: sv/pdb_conv.sv
`timescale 1ns / 1ps
`default_nettype none

module pdb_conv (
  input  wire logic               clk,
  input  wire logic               load,
  input  wire pdb_pkg::pdb_in_t   item,
  output pdb_pkg::pdb_conv_t      conv
);

  logic [pdb_pkg::X_W-1:0]                       x;
  logic [pdb_pkg::X_W+pdb_pkg::DIST_R_W-1:0]     prod;

  // x = us * 34 as shifts; the quotient estimate is low by at most one.
  assign x    = {1'b0, item.echo_us, 5'b0} + {5'b0, item.echo_us, 1'b0};
  assign prod = (pdb_pkg::X_W+pdb_pkg::DIST_R_W)'(x)
              * (pdb_pkg::X_W+pdb_pkg::DIST_R_W)'(pdb_pkg::DIST_R);

  always_ff @(posedge clk) begin
    if (load) begin
      conv.reversing <= item.reversing;
      conv.echo_ok   <= (item.echo_us != '0) &&
                        (item.echo_us <= pdb_pkg::ECHO_W'(pdb_pkg::ECHO_MAX));
      conv.x         <= x;
      conv.q0        <= prod[pdb_pkg::DIST_K +: pdb_pkg::DIST_W];
    end
  end

endmodule

`default_nettype wire

FILE: sv/pdb_ring.sv
`timescale 1ns / 1ps
`default_nettype none

module pdb_ring #(
  parameter  int WINDOW = 8,
  localparam int SUM_W  = $clog2(WINDOW * pdb_pkg::DIST_MAX + 1)
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       load,
  input  wire pdb_pkg::pdb_conv_t         conv,
  input  wire logic [pdb_pkg::IVL_W-1:0]  interval,
  output pdb_pkg::pdb_tick_t              tick,
  output logic [SUM_W-1:0]                sum
);

  localparam int IDX_W = $clog2(WINDOW);

  logic [pdb_pkg::DIST_W-1:0] mem [WINDOW];
  logic [pdb_pkg::DIST_W-1:0] rd_q;
  logic                       full;
  logic [IDX_W-1:0]           idx;
  logic [pdb_pkg::TIME_W-1:0] ms_count;
  logic [pdb_pkg::TIME_W-1:0] last_measure;
  logic [SUM_W-1:0]           ring_sum;

  logic [pdb_pkg::X_W-1:0]    prod125;
  logic [pdb_pkg::X_W-1:0]    rem;
  logic [pdb_pkg::DIST_W-1:0] d;
  logic [pdb_pkg::DIST_W-1:0] oldest;
  logic                       due;
  logic                       wr;
  logic [IDX_W-1:0]           idx_inc;
  logic [IDX_W-1:0]           idx_after;
  logic [IDX_W-1:0]           idx_next;
  logic [SUM_W-1:0]           ring_sum_next;
  logic [SUM_W-1:0]           sum_after;

  always_comb begin
    prod125 = pdb_pkg::X_W'(conv.q0) * pdb_pkg::X_W'(pdb_pkg::ECHO_DIV);
    rem     = conv.x - prod125;
    d       = conv.q0 + pdb_pkg::DIST_W'(rem >= pdb_pkg::X_W'(pdb_pkg::ECHO_DIV));
    // Entries not yet written since reset read as zero until the ring wraps.
    oldest  = full ? rd_q : '0;
    due     = conv.reversing &&
              ((ms_count - last_measure) >= pdb_pkg::TIME_W'(interval));
    wr      = due && conv.echo_ok;
    idx_inc = (idx == IDX_W'(WINDOW - 1)) ? '0 : idx + 1'b1;
    idx_after     = wr ? idx_inc : idx;
    idx_next      = load ? idx_after : idx;
    ring_sum_next = ring_sum - SUM_W'(oldest) + SUM_W'(d);
    sum_after     = wr ? ring_sum_next : ring_sum;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ms_count     <= '0;
      last_measure <= '0;
      ring_sum     <= '0;
      idx          <= '0;
      full         <= 1'b0;
    end else if (load) begin
      ms_count <= ms_count + 1'b1;
      if (due) begin
        last_measure <= ms_count;
      end
      if (wr) begin
        ring_sum <= ring_sum_next;
        idx      <= idx_inc;
        if (idx == IDX_W'(WINDOW - 1)) begin
          full <= 1'b1;
        end
      end
    end
  end

  // The read port always prefetches the entry the next write replaces.
  always_ff @(posedge clk) begin
    if (load && wr) begin
      mem[idx] <= d;
    end
    rd_q <= mem[idx_next];
  end

  always_ff @(posedge clk) begin
    if (load) begin
      tick.reversing <= conv.reversing;
      tick.measured  <= due;
      tick.refreshed <= due && (idx_after == '0);
      tick.now       <= ms_count;
      sum            <= sum_after;
    end
  end

endmodule

`default_nettype wire

FILE: sv/pdb_avg.sv
`timescale 1ns / 1ps
`default_nettype none

module pdb_avg #(
  parameter  int WINDOW = 8,
  localparam int SUM_W  = $clog2(WINDOW * pdb_pkg::DIST_MAX + 1)
) (
  input  wire logic                 clk,
  input  wire logic                 load,
  input  wire pdb_pkg::pdb_tick_t   tick_in,
  input  wire logic [SUM_W-1:0]     sum_in,
  output pdb_pkg::pdb_tick_t        tick,
  output logic [SUM_W-1:0]          sum,
  output logic [2*SUM_W-1:0]        prod
);

  // Reciprocal of the window length, scaled so the estimate is low by at most one.
  localparam int AVG_R = (2 ** SUM_W) / WINDOW;

  always_ff @(posedge clk) begin
    if (load) begin
      tick <= tick_in;
      sum  <= sum_in;
      prod <= (2*SUM_W)'(sum_in) * (2*SUM_W)'(AVG_R);
    end
  end

endmodule

`default_nettype wire

FILE: sv/pdb_tone.sv
`timescale 1ns / 1ps
`default_nettype none

module pdb_tone #(
  parameter  int WINDOW = 8,
  localparam int SUM_W  = $clog2(WINDOW * pdb_pkg::DIST_MAX + 1)
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 load,
  input  wire pdb_pkg::pdb_tick_t   tick,
  input  wire logic [SUM_W-1:0]     sum,
  input  wire logic [2*SUM_W-1:0]   prod,
  output pdb_pkg::pdb_out_t         result
);

  logic [pdb_pkg::DIST_W-1:0] average;
  logic [pdb_pkg::TIME_W-1:0] last_toggle;
  logic                       phase;
  logic                       tone_on;
  logic [pdb_pkg::FREQ_W-1:0] tone_freq;

  logic [pdb_pkg::DIST_W-1:0] q0;
  logic [SUM_W-1:0]           rem;
  logic [pdb_pkg::DIST_W-1:0] average_next;
  pdb_pkg::pdb_band_t         band;
  logic                       toggle_due;
  logic [pdb_pkg::TIME_W-1:0] last_toggle_next;
  logic                       phase_next;
  logic                       tone_on_next;
  logic [pdb_pkg::FREQ_W-1:0] tone_freq_next;

  always_comb begin
    q0   = prod[SUM_W +: pdb_pkg::DIST_W];
    rem  = sum - SUM_W'(q0) * SUM_W'(WINDOW);
    average_next = tick.refreshed
                 ? q0 + pdb_pkg::DIST_W'(rem >= SUM_W'(WINDOW))
                 : average;
    band = pdb_pkg::pick_band(average_next);
    toggle_due = (band.freq != '0) &&
                 ((tick.now - last_toggle) >= pdb_pkg::TIME_W'(band.period));

    last_toggle_next = last_toggle;
    phase_next       = phase;
    tone_on_next     = tone_on;
    tone_freq_next   = tone_freq;
    if (!tick.reversing || band.freq == '0) begin
      tone_on_next   = 1'b0;
      tone_freq_next = '0;
    end else if (toggle_due) begin
      last_toggle_next = tick.now;
      phase_next       = !phase;
      tone_on_next     = !phase;
      tone_freq_next   = phase ? '0 : band.freq;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      average     <= '0;
      last_toggle <= '0;
      phase       <= 1'b0;
      tone_on     <= 1'b0;
      tone_freq   <= '0;
    end else if (load) begin
      average     <= average_next;
      last_toggle <= last_toggle_next;
      phase       <= phase_next;
      tone_on     <= tone_on_next;
      tone_freq   <= tone_freq_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result.measured    <= tick.measured;
      result.new_average <= tick.refreshed;
      result.average_q4  <= average_next;
      result.sounding    <= tone_on_next;
      result.tone_hz     <= tone_on_next ? tone_freq_next : '0;
    end
  end

endmodule

`default_nettype wire

FILE: sv/parking_distance_beeper.sv
// Parking distance beeper: one item per millisecond tick, one result per item.
//
// The input channel (item_valid / item_stall / item) carries the reversing flag
// and the latest echo time. The output channel (result_valid / result_stall /
// result) returns the measurement and refresh flags, the moving average in
// sixteenths of a centimeter and the buzzer state with its tone frequency.
// cfg_wen / cfg_wdata write the minimum number of ticks between measurements;
// write it only while no item is in flight.
//
// The block is a four-register pipeline: echo conversion estimate, ring and
// tick timing, average reciprocal product, then band and toggle logic into the
// result register. A result follows its item through the conversion, ring and
// average registers; one item is accepted every cycle while result_stall is low.
// The reciprocal multipliers each end in a register, which sets the depth.
//
// Reset clears the tick time, the ring and sum, the average and the buzzer
// state, and sets the interval to 50. Each stage holds its item while the next
// one is full; while result_stall is high the empty stages still fill, and
// item_stall rises only once the first stage holds an item that cannot move.
`timescale 1ns / 1ps
`default_nettype none

module parking_distance_beeper #(
  parameter int WINDOW = 8
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        item_valid,
  output logic                             item_stall,
  input  wire pdb_pkg::pdb_in_t            item,
  output logic                             result_valid,
  input  wire logic                        result_stall,
  output pdb_pkg::pdb_out_t                result,
  input  wire logic                        cfg_wen,
  input  wire logic [pdb_pkg::IVL_W-1:0]   cfg_wdata
);

  localparam int SUM_W = $clog2(WINDOW * pdb_pkg::DIST_MAX + 1);

  logic [pdb_pkg::IVL_W-1:0] interval;
  logic                      s1_valid;
  logic                      s2_valid;
  logic                      s3_valid;
  logic                      out_ready;
  logic                      s3_ready;
  logic                      s2_ready;
  logic                      s1_ready;
  logic                      load1;
  logic                      load2;
  logic                      load3;
  logic                      load_out;

  pdb_pkg::pdb_conv_t        conv;
  pdb_pkg::pdb_tick_t        tick2;
  pdb_pkg::pdb_tick_t        tick3;
  logic [SUM_W-1:0]          sum2;
  logic [SUM_W-1:0]          sum3;
  logic [2*SUM_W-1:0]        prod3;

  always_comb begin
    out_ready  = !result_valid || !result_stall;
    s3_ready   = !s3_valid || out_ready;
    s2_ready   = !s2_valid || s3_ready;
    s1_ready   = !s1_valid || s2_ready;
    load1      = item_valid && s1_ready;
    load2      = s1_valid && s2_ready;
    load3      = s2_valid && s3_ready;
    load_out   = s3_valid && out_ready;
    item_stall = !s1_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      interval     <= pdb_pkg::IVL_W'(pdb_pkg::IVL_RESET);
      s1_valid     <= 1'b0;
      s2_valid     <= 1'b0;
      s3_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (cfg_wen) begin
        interval <= cfg_wdata;
      end
      s1_valid     <= load1 || (s1_valid && !load2);
      s2_valid     <= load2 || (s2_valid && !load3);
      s3_valid     <= load3 || (s3_valid && !load_out);
      result_valid <= load_out || (result_valid && result_stall);
    end
  end

  pdb_conv u_conv (
    .clk  (clk),
    .load (load1),
    .item (item),
    .conv (conv)
  );

  pdb_ring #(.WINDOW(WINDOW)) u_ring (
    .clk      (clk),
    .rst      (rst),
    .load     (load2),
    .conv     (conv),
    .interval (interval),
    .tick     (tick2),
    .sum      (sum2)
  );

  pdb_avg #(.WINDOW(WINDOW)) u_avg (
    .clk     (clk),
    .load    (load3),
    .tick_in (tick2),
    .sum_in  (sum2),
    .tick    (tick3),
    .sum     (sum3),
    .prod    (prod3)
  );

  pdb_tone #(.WINDOW(WINDOW)) u_tone (
    .clk    (clk),
    .rst    (rst),
    .load   (load_out),
    .tick   (tick3),
    .sum    (sum3),
    .prod   (prod3),
    .result (result)
  );

`ifndef SYNTHESIS
  a_tone_only_when_sounding: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.sounding || result.tone_hz == '0))
    else $error("tone frequency reported while silent");

  a_refresh_needs_measure: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.new_average) |-> result.measured)
    else $error("average refreshed without a measurement");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> (s1_valid && s2_valid && s3_valid && result_valid))
    else $error("input stalled with an empty stage");

  a_last_stage_drains: assert property (@(posedge clk) disable iff (rst)
    (s3_valid && !result_valid) |=> result_valid)
    else $error("item lost between last stage and result register");
`endif

endmodule

`default_nettype wire
